// ===== src/ilid_pkg.sv =====
// shared types and codes for the indexed list block
`timescale 1ns / 1ps
`default_nettype none

package ilid_pkg;

    // command codes
    localparam logic [2:0] CMD_GET      = 3'd0;
    localparam logic [2:0] CMD_INS_HEAD = 3'd1;
    localparam logic [2:0] CMD_APPEND   = 3'd2;
    localparam logic [2:0] CMD_INS_AT   = 3'd3;
    localparam logic [2:0] CMD_DELETE   = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // widths fixed by the field formats and the largest supported depth
    localparam int DATA_W = 32;
    localparam int AT_W   = 11;

    localparam logic [DATA_W-1:0] READ_INVALID = '1;

    // broadcast to every cell of the row
    typedef struct packed {
        logic            ins;
        logic            del;
        logic            rd;
        logic [AT_W-1:0] at;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== src/ilid_cell.sv =====
// one list slot: holds an element and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module ilid_cell #(
    parameter int INDEX = 0
) (
    input  wire                              i_clk,
    input  ilid_pkg::t_cell_ctl              i_ctl,
    input  wire  [ilid_pkg::DATA_W-1:0]      i_value,
    input  wire  [ilid_pkg::DATA_W-1:0]      i_left,
    input  wire  [ilid_pkg::DATA_W-1:0]      i_right,
    output logic [ilid_pkg::DATA_W-1:0]      o_data,
    output logic [ilid_pkg::DATA_W-1:0]      o_read
);

    logic [ilid_pkg::DATA_W-1:0] r_data;
    logic [ilid_pkg::DATA_W-1:0] n_data;
    logic                        w_here;
    logic                        w_past;

    assign w_here = (i_ctl.at == ilid_pkg::AT_W'(INDEX));
    assign w_past = (ilid_pkg::AT_W'(INDEX) > i_ctl.at);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (w_here) begin
                n_data = i_value;
            end else if (w_past) begin
                n_data = i_left;
            end
        end else if (i_ctl.del) begin
            if (w_here || w_past) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // masked so the gather stage can simply or all cells together
    assign o_read = r_data & {ilid_pkg::DATA_W{i_ctl.rd && w_here}};

endmodule

`default_nettype wire

// ===== src/indexed_list_insert_delete.sv =====
// top level: indexed list kept in a row of shifting cells
//
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+----------------------------------
// in      | request   | i_in_valid / o_in_stall    | i_cmd, i_position, i_item_value
// out     | result    | o_out_valid / i_out_stall  | o_read_value, o_status, o_count
//
// a request passes through latch, decode + cell shift, and gather of the get data
// one request in flight at a time, so a new request is taken only once the last
// has left the gather stage, a two-level or tree that picks the cell for a get
// the output register lets the next request start while a result waits
// reset is synchronous active low; it clears the length and all valid flags,
// cell contents are left as they are and are never read before written
// a stalled result holds the gather stage, which in turn stalls the input
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_delete #(
    parameter int DEPTH = 64,
    parameter int LW    = 7     // must be $clog2(DEPTH + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // request channel
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  [2:0]               i_cmd,
    input  wire  signed [7:0]        i_position,
    input  wire  signed [31:0]       i_item_value,
    // result channel
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic signed [31:0]       o_read_value,
    output logic [1:0]               o_status,
    output logic [LW-1:0]            o_count
);

    localparam int DW     = ilid_pkg::DATA_W;
    localparam int AW     = ilid_pkg::AT_W;
    localparam int GROUP  = 8;
    localparam int NG     = (DEPTH + GROUP - 1) / GROUP;

    // handshake
    logic w_in_acc;
    logic w_out_acc;
    logic w_s2_move;

    // latched request
    logic          r_s1;
    logic [2:0]    r_cmd;
    logic [7:0]    r_pos;
    logic [DW-1:0] r_val;

    // list length
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;

    // decode
    ilid_pkg::t_cell_ctl w_ctl;
    logic [AW-1:0]       w_posu;
    logic [AW-1:0]       w_len;
    logic                w_neg;
    logic                w_bad;
    logic                w_full;
    logic                w_is_ins;
    logic [1:0]          w_st;

    // cell row
    logic [DW-1:0] w_q  [DEPTH];
    logic [DW-1:0] w_rd [DEPTH];

    // gather stage
    logic          r_s2;
    logic [DW-1:0] r_grp [NG];
    logic [DW-1:0] n_grp [NG];
    logic [1:0]    r_st;
    logic [LW-1:0] r_cnt;
    logic          r_is_get;
    logic          r_get_bad;
    logic [DW-1:0] w_gather;

    // output register
    logic          r_ov;
    logic [DW-1:0] r_out_val;
    logic [1:0]    r_out_st;
    logic [LW-1:0] r_out_cnt;

    // one request in decode or gather at a time
    assign o_in_stall = r_s1 | r_s2;
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_acc  = r_ov & ~i_out_stall;
    assign w_s2_move  = r_s2 & (~r_ov | ~i_out_stall);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= i_cmd;
            r_pos <= i_position;
            r_val <= i_item_value;
        end
    end

    // command decode against the current length
    assign w_neg  = r_pos[7];
    assign w_posu = AW'(r_pos[6:0]);
    assign w_len  = AW'(r_len);
    assign w_full = (r_len == LW'(DEPTH));

    always_comb begin
        w_ctl    = '0;
        w_bad    = 1'b0;
        w_is_ins = 1'b0;
        case (r_cmd)
            ilid_pkg::CMD_GET: begin
                w_ctl.rd = r_s1;
                w_ctl.at = w_posu;
                w_bad    = w_neg || (w_posu >= w_len);
            end
            ilid_pkg::CMD_INS_HEAD: begin
                w_is_ins = 1'b1;
                w_ctl.at = '0;
            end
            ilid_pkg::CMD_APPEND: begin
                w_is_ins = 1'b1;
                w_ctl.at = w_len;
            end
            ilid_pkg::CMD_INS_AT: begin
                // a negative index inserts at the head
                w_is_ins = 1'b1;
                w_ctl.at = w_neg ? '0 : w_posu;
                w_bad    = !w_neg && (w_posu > w_len);
            end
            ilid_pkg::CMD_DELETE: begin
                w_ctl.at = w_posu;
                w_bad    = w_neg || (w_posu >= w_len);
                w_ctl.del = r_s1 && !w_bad;
            end
            default: begin
                w_bad = 1'b1;
            end
        endcase
        w_ctl.ins = r_s1 && w_is_ins && !w_bad && !w_full;
        if (w_bad) begin
            w_st = ilid_pkg::ST_BAD_INDEX;
        end else if (w_is_ins && w_full) begin
            w_st = ilid_pkg::ST_FULL;
        end else begin
            w_st = ilid_pkg::ST_DONE;
        end
    end

    always_comb begin
        n_len = r_len;
        if (w_ctl.ins) begin
            n_len = r_len + LW'(1);
        end else if (w_ctl.del) begin
            n_len = r_len - LW'(1);
        end
    end

    // row of cells, each talking only to its two neighbors
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DW-1:0] w_left;
        logic [DW-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = r_val;
        end else begin : g_mid_l
            assign w_left = w_q[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = w_q[k];
        end else begin : g_mid_r
            assign w_right = w_q[k+1];
        end
        ilid_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (r_val),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_q[k]),
            .o_read  (w_rd[k])
        );
    end

    // first level of the gather tree: or of each group of eight cells
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < DEPTH) begin
                    n_grp[g] = n_grp[g] | w_rd[g * GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1) begin
            r_grp     <= n_grp;
            r_st      <= w_st;
            r_cnt     <= n_len;
            r_is_get  <= (r_cmd == ilid_pkg::CMD_GET);
            r_get_bad <= w_bad;
        end
    end

    // second level of the gather tree
    always_comb begin
        w_gather = '0;
        for (int g = 0; g < NG; g++) begin
            w_gather = w_gather | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_move) begin
            r_out_st  <= r_st;
            r_out_cnt <= r_cnt;
            if (!r_is_get) begin
                r_out_val <= '0;
            end else if (r_get_bad) begin
                r_out_val <= ilid_pkg::READ_INVALID;
            end else begin
                r_out_val <= w_gather;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= 1'b0;
            r_s2  <= 1'b0;
            r_ov  <= 1'b0;
            r_len <= '0;
        end else begin
            r_len <= n_len;
            r_s1  <= w_in_acc;
            if (r_s1) begin
                r_s2 <= 1'b1;
            end else if (w_s2_move) begin
                r_s2 <= 1'b0;
            end
            if (w_s2_move) begin
                r_ov <= 1'b1;
            end else if (w_out_acc) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_read_value = r_out_val;
    assign o_status     = r_out_st;
    assign o_count      = r_out_cnt;

    // the list never grows past its capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("list length above capacity");

    // no insert is ever applied to a full list
    a_no_full_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |-> !w_full)
        else $error("insert applied to full list");

    // a request never sits in decode and gather at once
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_s1, r_s2}))
        else $error("two requests in flight");

    // every decoded request reaches the gather stage next cycle
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1 |=> r_s2)
        else $error("decoded request lost");

endmodule

`default_nettype wire
